[hdl/qrap_pkg.sv]
`default_nettype none

package qrap_pkg;

  // Input columns carried by one item
  localparam int unsigned NUM_ROW_FIELDS = 7;
  localparam int unsigned PIXEL_W        = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Pipeline: lanes, merge, then six requantisation stages
  localparam int unsigned RQ_STAGES  = 6;
  localparam int unsigned NUM_STAGES = RQ_STAGES + 2;

  typedef logic [PIXEL_W-1:0]    pixel_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [RQ_STAGES-1:0]  rq_load_t;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT  = 3'd0,
    REG_BIAS       = 3'd1,
    REG_SCALE_MULT = 3'd2,
    REG_ROUNDING   = 3'd3,
    REG_SHIFT      = 3'd4,
    REG_ZERO_POINT = 3'd5,
    REG_CLAMP_LOW  = 3'd6,
    REG_CLAMP_HIGH = 3'd7
  } cfg_reg_e;

  // Requantisation settings shared with the datapath
  typedef struct packed {
    logic [31:0] scale_multiplier;
    logic [63:0] rounding_term;
    logic [5:0]  shift_amount;
    logic [15:0] zero_point;
    logic [7:0]  clamp_low;
    logic [7:0]  clamp_high;
  } rq_cfg_t;

  // Reset values
  localparam logic [2:0]  ROW_COUNT_RST  = 3'd7;
  localparam logic [31:0] SCALE_MULT_RST = 32'd1;
  localparam logic [7:0]  CLAMP_HIGH_RST = 8'd255;

endpackage

`default_nettype wire

[hdl/qrap_if.sv]
`default_nettype none

// Input channel: one channel column of row values
interface qrap_in_if;
  import qrap_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t row0_pixel;
  pixel_t row1_pixel;
  pixel_t row2_pixel;
  pixel_t row3_pixel;
  pixel_t row4_pixel;
  pixel_t row5_pixel;
  pixel_t row6_pixel;
  logic   last_channel;

  modport source (
    output valid, row0_pixel, row1_pixel, row2_pixel, row3_pixel,
           row4_pixel, row5_pixel, row6_pixel, last_channel,
    input  ready
  );
  modport sink (
    input  valid, row0_pixel, row1_pixel, row2_pixel, row3_pixel,
           row4_pixel, row5_pixel, row6_pixel, last_channel,
    output ready
  );
endinterface

// Output channel: one pooled byte per channel
interface qrap_out_if;
  import qrap_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t pooled_value;
  logic   last_channel_out;

  modport source (output valid, pooled_value, last_channel_out, input ready);
  modport sink   (input valid, pooled_value, last_channel_out, output ready);
endinterface

// Configuration write channel
interface qrap_cfg_if;
  import qrap_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/qrap_lane.sv]
`default_nettype none

// One row lane: gates the row value by the row count and registers it
module qrap_lane
  import qrap_pkg::*;
#(
  parameter int unsigned ROW = 0
) (
  input  wire logic       clk,
  input  wire logic       load,
  input  wire logic [2:0] row_count,
  input  wire pixel_t     pixel,
  output pixel_t          gated
);

  logic row_used;

  // row zero always counts; later rows only below the count
  assign row_used = (ROW == 0) || (3'(ROW) < row_count);

  always_ff @(posedge clk) begin
    if (load) begin
      gated <= row_used ? pixel : '0;
    end
  end

endmodule

`default_nettype wire

[hdl/qrap_merge.sv]
`default_nettype none

// Merge stage: sums the lane outputs and adds the bias (wraps mod 2^32)
module qrap_merge
  import qrap_pkg::*;
#(
  parameter int unsigned NUM_LANES = 7
) (
  input  wire logic        clk,
  input  wire logic        load,
  input  wire logic [31:0] bias,
  input  wire pixel_t      lane_val [NUM_LANES],
  output logic [31:0]      acc
);

  localparam int unsigned SUM_W = PIXEL_W + $clog2(NUM_LANES + 1);

  logic [SUM_W-1:0] sum;

  always_comb begin
    sum = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      sum = sum + SUM_W'(lane_val[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc <= bias + 32'(sum);
    end
  end

endmodule

`default_nettype wire

[hdl/qrap_requant.sv]
`default_nettype none

// Requantisation pipeline: magnitude, multiply, round, shift,
// sign restore with int16 saturation, then zero point and clamps
module qrap_requant
  import qrap_pkg::*;
(
  input  wire logic        clk,
  input  wire rq_load_t    load,
  input  wire rq_cfg_t     cfg,
  input  wire logic [31:0] acc,
  output pixel_t           pooled
);

  logic               neg3, neg4, neg5, neg6;
  logic [31:0]        mag;
  logic [63:0]        prod;
  logic [63:0]        rnd;
  logic [31:0]        low;
  logic signed [15:0] v16;

  logic signed [31:0] restored;
  logic signed [15:0] v16_next;
  logic signed [16:0] zp_sum;
  logic [7:0]         byte_val;
  logic [7:0]         pooled_next;

  // Stage: sign and magnitude
  always_ff @(posedge clk) begin
    if (load[0]) begin
      neg3 <= acc[31];
      mag  <= acc[31] ? (32'd0 - acc) : acc;
    end
  end

  // Stage: 32x32 multiply
  always_ff @(posedge clk) begin
    if (load[1]) begin
      neg4 <= neg3;
      prod <= 64'(mag) * 64'(cfg.scale_multiplier);
    end
  end

  // Stage: rounding add, wraps mod 2^64
  always_ff @(posedge clk) begin
    if (load[2]) begin
      neg5 <= neg4;
      rnd  <= prod + cfg.rounding_term;
    end
  end

  // Stage: logical shift, keep low word
  always_ff @(posedge clk) begin
    if (load[3]) begin
      neg6 <= neg5;
      low  <= 32'(rnd >> cfg.shift_amount);
    end
  end

  // Stage: restore sign, saturate to int16
  always_comb begin
    restored = neg6 ? $signed(32'd0 - low) : $signed(low);
    if (restored > 32'sd32767) begin
      v16_next = 16'sh7FFF;
    end else if (restored < -32'sd32768) begin
      v16_next = 16'sh8000;
    end else begin
      v16_next = 16'(restored);
    end
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      v16 <= v16_next;
    end
  end

  // Stage: zero point, byte range, upper then lower clamp
  always_comb begin
    zp_sum = 17'(v16) + 17'($signed(cfg.zero_point));
    if (zp_sum < 17'sd0) begin
      byte_val = 8'd0;
    end else if (zp_sum > 17'sd255) begin
      byte_val = 8'd255;
    end else begin
      byte_val = 8'(zp_sum);
    end
    pooled_next = byte_val;
    if (pooled_next > cfg.clamp_high) begin
      pooled_next = cfg.clamp_high;
    end
    if (pooled_next < cfg.clamp_low) begin
      pooled_next = cfg.clamp_low;
    end
  end

  always_ff @(posedge clk) begin
    if (load[5]) begin
      pooled <= pooled_next;
    end
  end

endmodule

`default_nettype wire

[hdl/quantized_row_average_pool.sv]
// Quantized row average pool. Each input transfer carries one channel column of
// up to seven unsigned row bytes; rows at or beyond row_count read as zero (row 0
// always counts). The sum plus bias is requantised in sign-magnitude form with a
// 32x32 multiply, 64-bit rounding add and logical shift, then saturated, offset by
// the zero point and clamped to [clamp_low, clamp_high]. Throughput is one item
// per clock while the output is not back-pressured; the stages are one lane stage,
// one merge stage and six requantisation stages, with the 32x32 multiplier
// in a stage of its own. Each stage holds its item while the next is full, so
// bubbles close up under output back-pressure. Configuration writes are taken
// every cycle and must only be made while the pipeline is empty.
`default_nettype none

module quantized_row_average_pool
  import qrap_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 7
) (
  input  wire logic clk,
  input  wire logic rst,
  qrap_in_if.sink   in_ch,
  qrap_out_if.source out_ch,
  qrap_cfg_if.sink  cfg
);

  // Configuration registers
  logic [2:0]  row_count;
  logic [31:0] bias;
  rq_cfg_t     rq_cfg;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count                <= ROW_COUNT_RST;
      bias                     <= '0;
      rq_cfg.scale_multiplier  <= SCALE_MULT_RST;
      rq_cfg.rounding_term     <= '0;
      rq_cfg.shift_amount      <= '0;
      rq_cfg.zero_point        <= '0;
      rq_cfg.clamp_low         <= '0;
      rq_cfg.clamp_high        <= CLAMP_HIGH_RST;
    end else if (cfg.valid) begin
      case (cfg_reg_e'(cfg.index))
        REG_ROW_COUNT:  row_count               <= cfg.data[2:0];
        REG_BIAS:       bias                    <= cfg.data[31:0];
        REG_SCALE_MULT: rq_cfg.scale_multiplier <= cfg.data[31:0];
        REG_ROUNDING:   rq_cfg.rounding_term    <= cfg.data;
        REG_SHIFT:      rq_cfg.shift_amount     <= cfg.data[5:0];
        REG_ZERO_POINT: rq_cfg.zero_point       <= cfg.data[15:0];
        REG_CLAMP_LOW:  rq_cfg.clamp_low        <= cfg.data[7:0];
        REG_CLAMP_HIGH: rq_cfg.clamp_high       <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // Stage occupancy and load enables; a stage loads when empty or draining
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] load;
  logic [NUM_STAGES-1:0] last_pipe;

  always_comb begin
    load[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ch.ready;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      load[s] = !vld[s] || load[s+1];
    end
  end

  assign in_ch.ready = load[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) begin
        vld[0] <= in_ch.valid;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (load[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  // last flag rides alongside the data
  always_ff @(posedge clk) begin
    if (load[0]) begin
      last_pipe[0] <= in_ch.last_channel;
    end
    for (int s = 1; s < NUM_STAGES; s++) begin
      if (load[s]) begin
        last_pipe[s] <= last_pipe[s-1];
      end
    end
  end

  // Row lanes
  pixel_t rows [NUM_ROW_FIELDS];
  pixel_t lane_val [MAX_ROWS];

  assign rows[0] = in_ch.row0_pixel;
  assign rows[1] = in_ch.row1_pixel;
  assign rows[2] = in_ch.row2_pixel;
  assign rows[3] = in_ch.row3_pixel;
  assign rows[4] = in_ch.row4_pixel;
  assign rows[5] = in_ch.row5_pixel;
  assign rows[6] = in_ch.row6_pixel;

  for (genvar k = 0; k < MAX_ROWS; k++) begin : g_lane
    qrap_lane #(
      .ROW (k)
    ) u_lane (
      .clk       (clk),
      .load      (load[0]),
      .row_count (row_count),
      .pixel     (rows[k]),
      .gated     (lane_val[k])
    );
  end

  // Merge
  logic [31:0] acc;

  qrap_merge #(
    .NUM_LANES (MAX_ROWS)
  ) u_merge (
    .clk      (clk),
    .load     (load[1]),
    .bias     (bias),
    .lane_val (lane_val),
    .acc      (acc)
  );

  // Requantisation
  pixel_t pooled;

  qrap_requant u_requant (
    .clk    (clk),
    .load   (load[NUM_STAGES-1:2]),
    .cfg    (rq_cfg),
    .acc    (acc),
    .pooled (pooled)
  );

  assign out_ch.valid            = vld[NUM_STAGES-1];
  assign out_ch.pooled_value     = pooled;
  assign out_ch.last_channel_out = last_pipe[NUM_STAGES-1];

endmodule

`default_nettype wire
